// ===== src/sidta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_pkg: shared types and constants for the decimal text converter
// Sizes of the binary and BCD datapaths, ASCII codes, controller states and
// the control bundle that drives the bit-serial converter core.
// ----------------------------------------------------------------------------
package sidta_pkg;

  // Width of the integer actually converted; bit VALUE_BITS-1 is the sign.
  localparam int VALUE_BITS = 64;

  // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
  // floor(n * log10(2)) + 1 is exact over the supported range.
  localparam int DIGITS   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS = 4 * DIGITS;
  localparam int DIG_W    = $clog2(DIGITS);
  localparam int CNT_W    = $clog2(VALUE_BITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } sidta_state_t;

  typedef struct packed {
    logic load;        // start a conversion of the supplied magnitude
    logic next_digit;  // shift the BCD register up by one digit
  } sidta_ctrl_t;

endpackage

// ===== src/sidta_dabble.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_dabble: bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one magnitude bit per cycle, followed by a
// digit-wide shift-out of the BCD result, most significant digit first.
// ----------------------------------------------------------------------------
module sidta_dabble
  import sidta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  sidta_ctrl_t           ctrl,
  input  logic [VALUE_BITS-1:0] mag,
  output logic                  done,
  output logic [3:0]            top_digit
);

  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_BITS-1:0]   bcd_r, bcd_nxt;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;

  // Each digit of five or more is corrected before the next doubling.
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (ctrl.load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(VALUE_BITS - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {bcd_adj[BCD_BITS-2:0], bin_r[VALUE_BITS-1]};
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end else if (ctrl.next_digit) begin
      bcd_nxt = {bcd_r[BCD_BITS-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done      = !run_r;
  assign top_digit = bcd_r[BCD_BITS-1 -: 4];

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts each signed integer to its decimal characters, sign first, most
// significant digit first, with a flag on the final character.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                | Direction
//  --------+--------------------------------------+----------
//  input   | in_valid, in_stall, in_value         | in
//  result  | out_valid, out_stall, out_character, | out
//          | out_last                             |
//
//  One number holds the block through the bit-serial conversion, then the
//  minus sign of a negative value, the suppressed leading zeros, the step
//  that leaves the zero skip and the digits, plus any result stalls. Reset
//  is synchronous and active low and clears the controller and the output
//  valid. A stall on the result side holds the current character and
//  pauses emission.
//
module signed_int_to_decimal_ascii
  import sidta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_character,
  output logic        out_last
);

  sidta_state_t          state_r, state_nxt;
  sidta_ctrl_t           ctrl;
  logic                  core_done;
  logic [3:0]            top_digit;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] mag;

  logic             neg_r, neg_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       oc_r, oc_nxt;
  logic             ol_r, ol_nxt;
  logic             out_free;

  assign val      = in_value[VALUE_BITS-1:0];
  // The most negative value negates onto itself, which is its magnitude.
  assign mag      = val[VALUE_BITS-1] ? (~val + VALUE_BITS'(1)) : val;
  assign out_free = !ov_r || !out_stall;

  sidta_dabble u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .mag       (mag),
    .done      (core_done),
    .top_digit (top_digit)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (core_done) state_nxt = neg_r ? ST_SIGN : ST_SKIP;
      end
      ST_SIGN: begin
        if (out_free) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (top_digit != 4'd0 || dig_r == '0) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && dig_r == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    in_stall        = 1'b1;
    ctrl.load       = 1'b0;
    ctrl.next_digit = 1'b0;
    neg_nxt         = neg_r;
    dig_nxt         = dig_r;
    ov_nxt          = ov_r && out_stall;
    oc_nxt          = oc_r;
    ol_nxt          = ol_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load = 1'b1;
          neg_nxt   = val[VALUE_BITS-1];
          dig_nxt   = DIG_W'(DIGITS - 1);
        end
      end
      ST_CONV: begin
      end
      ST_SIGN: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          oc_nxt = CHAR_MINUS;
          ol_nxt = 1'b0;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && dig_r != '0) begin
          ctrl.next_digit = 1'b1;
          dig_nxt         = dig_r - DIG_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt          = 1'b1;
          oc_nxt          = CHAR_ZERO + {4'd0, top_digit};
          ol_nxt          = (dig_r == '0);
          ctrl.next_digit = 1'b1;
          if (dig_r != '0) dig_nxt = dig_r - DIG_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      neg_r   <= 1'b0;
      dig_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      neg_r   <= neg_nxt;
      dig_r   <= dig_nxt;
    end
    oc_r <= oc_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid     = ov_r;
  assign out_character = oc_r;
  assign out_last      = ol_r;

endmodule
